[src/cser_pkg.sv]
// ----------------------------------------------------------------------------
// cser_pkg
// Shared types and codes for the CPU standby event register block.
// ----------------------------------------------------------------------------
package cser_pkg;

  localparam int MAX_CPUS_DEF = 64;

  // register offsets
  localparam logic [3:0] OFF_SELECTOR = 4'd0;
  localparam logic [3:0] OFF_FLAGS    = 4'd4;
  localparam logic [3:0] OFF_COMMAND  = 4'd5;
  localparam logic [3:0] OFF_DATA     = 4'd8;

  // actions
  localparam logic [1:0] ACT_READ    = 2'd0;
  localparam logic [1:0] ACT_WRITE   = 2'd1;
  localparam logic [1:0] ACT_RESUME  = 2'd2;
  localparam logic [1:0] ACT_STANDBY = 2'd3;

  // commands
  localparam logic [1:0]  CMD_GET_NEXT   = 2'd0;
  localparam logic [1:0]  CMD_OST_EVENT  = 2'd1;
  localparam logic [1:0]  CMD_OST_STATUS = 2'd2;
  localparam logic [31:0] CMD_LIMIT      = 32'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_CPU_COUNT     = 2'd0;
  localparam logic [1:0] CFG_PRESENT_MASK  = 2'd1;
  localparam logic [1:0] CFG_BOOT_CPU      = 2'd2;
  localparam logic [1:0] CFG_MACHINE_READY = 2'd3;

  typedef struct packed {
    logic load;   // latch the accepted transfer
    logic exec;   // evaluate the access
    logic step;   // one get-next search step
  } cser_cmd_t;

  typedef struct packed {
    logic need_search;
    logic search_done;
  } cser_stat_t;

endpackage

[src/cser_ram.sv]
// ----------------------------------------------------------------------------
// cser_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cser_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/cser_ctrl.sv]
// ----------------------------------------------------------------------------
// cser_ctrl
// Sequencer: accept, execute, optional get-next search, deliver result.
// ----------------------------------------------------------------------------
module cser_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cser_pkg::cser_cmd_t  cmd,
  input  cser_pkg::cser_stat_t stat
);
  import cser_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_OUT
  } state_t;

  state_t state;

  assign cmd.load = in_valid && in_ready;
  assign cmd.exec = (state == S_EXEC);
  assign cmd.step = (state == S_SEARCH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= S_EXEC;
            in_ready <= 1'b0;
          end else begin
            in_ready <= 1'b1;
          end
        end
        S_EXEC: begin
          if (stat.need_search) begin
            state <= S_SEARCH;
          end else begin
            state     <= S_OUT;
            out_valid <= 1'b1;
          end
        end
        S_SEARCH: begin
          if (stat.search_done) begin
            state     <= S_OUT;
            out_valid <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            state     <= S_IDLE;
            out_valid <= 1'b0;
            in_ready  <= 1'b1;
          end
        end
        default: begin
          state     <= S_IDLE;
          out_valid <= 1'b0;
          in_ready  <= 1'b1;
        end
      endcase
    end
  end

endmodule

[src/cser_dp.sv]
// ----------------------------------------------------------------------------
// cser_dp
// Register file, per-CPU flags, OST event store, search and result registers.
// ----------------------------------------------------------------------------
module cser_dp #(
  parameter int MAX_CPUS = cser_pkg::MAX_CPUS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cser_pkg::cser_cmd_t  cmd,
  output cser_pkg::cser_stat_t stat,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic [1:0]           action,
  input  logic [3:0]           reg_offset,
  input  logic [31:0]          write_data,
  input  logic [5:0]           cpu_index,
  output logic [31:0]          read_data,
  output logic                 notify_host,
  output logic                 eject_valid,
  output logic [5:0]           eject_cpu,
  output logic                 ost_valid,
  output logic [5:0]           ost_cpu,
  output logic [31:0]          ost_event_code,
  output logic [31:0]          ost_status_code
);
  import cser_pkg::*;

  localparam int IDX_W = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int CNT_W = $clog2(MAX_CPUS + 1);
  localparam logic [6:0] MAX_N7 = 7'(MAX_CPUS);

  // configuration
  logic [6:0]  cpu_count;
  logic [63:0] present_mask;
  logic [5:0]  boot_cpu;
  logic        machine_ready;

  // architectural state
  logic [31:0]         selected_cpu;
  logic [1:0]          cur_cmd;
  logic [MAX_CPUS-1:0] dc_flags;
  logic [MAX_CPUS-1:0] ej_flags;
  logic [MAX_CPUS-1:0] ev_valid;

  // latched transfer
  logic [1:0]  act_q;
  logic [3:0]  off_q;
  logic [31:0] data_q;
  logic [5:0]  cpu_q;

  // search
  logic [IDX_W-1:0] it_q;
  logic [CNT_W-1:0] k_q;
  logic [CNT_W:0]   it_inc;
  logic [CNT_W:0]   k_inc;
  logic [CNT_W:0]   live_w;
  logic             pend;

  logic [CNT_W-1:0] live_n;
  logic             s_in_range;
  logic             cpu_ok;
  logic [IDX_W-1:0] s_idx;
  logic [IDX_W-1:0] c_idx;
  logic             pres_s;
  logic [31:0]      rd_val;
  logic [31:0]      ram_q;
  logic             ram_we;
  logic             wr_in;

  assign live_n     = (cpu_count > MAX_N7) ? CNT_W'(MAX_CPUS) : cpu_count[CNT_W-1:0];
  assign live_w     = (CNT_W+1)'(live_n);
  assign s_in_range = selected_cpu < 32'(live_n);
  assign cpu_ok     = (32'(cpu_q) < 32'(live_n)) && present_mask[cpu_q];
  assign s_idx      = selected_cpu[IDX_W-1:0];
  assign c_idx      = cpu_q[IDX_W-1:0];
  assign pres_s     = present_mask[selected_cpu[5:0]];
  assign wr_in      = (act_q == ACT_WRITE) && (off_q != OFF_SELECTOR) && s_in_range;

  always_comb begin
    rd_val = 32'd0;
    if (s_in_range) begin
      if (off_q == OFF_FLAGS) begin
        rd_val = {26'd0, pres_s, 2'b00, ej_flags[s_idx], dc_flags[s_idx], 1'b0};
      end else if (off_q == OFF_DATA && cur_cmd == CMD_GET_NEXT) begin
        rd_val = selected_cpu;
      end
    end
  end

  assign pend   = dc_flags[it_q] | ej_flags[it_q];
  assign it_inc = (CNT_W+1)'(it_q) + 1'b1;
  assign k_inc  = (CNT_W+1)'(k_q) + 1'b1;

  assign stat.need_search = wr_in && (off_q == OFF_COMMAND) && (data_q < CMD_LIMIT)
                            && (data_q[1:0] == CMD_GET_NEXT);
  assign stat.search_done = pend || (k_inc == live_w);

  assign ram_we = cmd.exec && wr_in && (off_q == OFF_DATA) && (cur_cmd == CMD_OST_EVENT);

  cser_ram #(
    .WIDTH (32),
    .DEPTH (MAX_CPUS)
  ) u_ev_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s_idx),
    .wdata (data_q),
    .raddr (s_idx),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_count     <= 7'd64;
      present_mask  <= '1;
      boot_cpu      <= 6'd0;
      machine_ready <= 1'b0;
      selected_cpu  <= 32'd0;
      cur_cmd       <= CMD_GET_NEXT;
      dc_flags      <= '0;
      ej_flags      <= '0;
      ev_valid      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CPU_COUNT:     cpu_count     <= cfg_data[6:0];
          CFG_PRESENT_MASK:  present_mask  <= cfg_data;
          CFG_BOOT_CPU:      boot_cpu      <= cfg_data[5:0];
          CFG_MACHINE_READY: machine_ready <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.exec) begin
        case (act_q)
          ACT_WRITE: begin
            if (off_q == OFF_SELECTOR) begin
              selected_cpu <= data_q;
            end else if (s_in_range) begin
              if (off_q == OFF_FLAGS) begin
                if (data_q[1]) begin
                  dc_flags[s_idx] <= 1'b0;
                end else if (data_q[2]) begin
                  ej_flags[s_idx] <= 1'b0;
                end
              end else if (off_q == OFF_COMMAND && data_q < CMD_LIMIT) begin
                cur_cmd <= data_q[1:0];
              end else if (off_q == OFF_DATA && cur_cmd == CMD_OST_EVENT) begin
                ev_valid[s_idx] <= 1'b1;
              end
            end
          end
          ACT_RESUME: begin
            if (cpu_ok && machine_ready) begin
              dc_flags[c_idx] <= 1'b1;
            end
          end
          ACT_STANDBY: begin
            if (cpu_ok) begin
              ej_flags[c_idx] <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (cmd.step && pend) begin
        selected_cpu <= 32'(it_q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q  <= action;
      off_q  <= reg_offset;
      data_q <= write_data;
      cpu_q  <= cpu_index;
    end
    if (cmd.exec) begin
      read_data       <= 32'd0;
      notify_host     <= 1'b0;
      eject_valid     <= 1'b0;
      eject_cpu       <= 6'd0;
      ost_valid       <= 1'b0;
      ost_cpu         <= 6'd0;
      ost_event_code  <= 32'd0;
      ost_status_code <= 32'd0;
      it_q            <= s_idx;
      k_q             <= '0;
      case (act_q)
        ACT_READ: read_data <= rd_val;
        ACT_WRITE: begin
          if (wr_in && off_q == OFF_FLAGS && !data_q[1] && !data_q[2] && data_q[3]
              && pres_s && selected_cpu[5:0] != boot_cpu) begin
            eject_valid <= 1'b1;
            eject_cpu   <= selected_cpu[5:0];
          end
          if (wr_in && off_q == OFF_DATA && cur_cmd == CMD_OST_STATUS) begin
            ost_valid       <= 1'b1;
            ost_cpu         <= selected_cpu[5:0];
            ost_event_code  <= ev_valid[s_idx] ? ram_q : 32'd0;
            ost_status_code <= data_q;
          end
        end
        ACT_RESUME:  notify_host <= cpu_ok && machine_ready;
        ACT_STANDBY: notify_host <= cpu_ok;
        default: ;
      endcase
    end
    if (cmd.step) begin
      it_q <= (it_inc < live_w) ? it_inc[IDX_W-1:0] : '0;
      k_q  <= k_inc[CNT_W-1:0];
    end
  end

endmodule

[src/cpu_standby_event_registers.sv]
// ----------------------------------------------------------------------------
// cpu_standby_event_registers
// Firmware register window for CPU resume/standby events and OST reports.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one access: register read,
// register write, resume request or standby request. Output channel
// (out_valid/out_ready) returns exactly one result per access.
// One access is handled at a time: the next input transfer waits until the
// result has been taken, and the result is registered in the execute state
// before it is offered. A get-next command write adds a search that visits
// up to the live CPU count of CPUs (one flag pair per cycle).
// The OST event RAM read in the transfer cycle is ready by the execute state.
// While the receiver stalls, the result holds and in_ready stays low.
// Reset clears selector, command, all pending flags and OST event words
// (per-entry valid bits), and restores cpu_count 64, all CPUs present,
// boot CPU 0, machine not ready; in_ready rises the cycle after reset.
// Configuration writes via cfg_we take effect on the next cycle and should
// only be issued while idle.
// ----------------------------------------------------------------------------
module cpu_standby_event_registers #(
  parameter int MAX_CPUS = cser_pkg::MAX_CPUS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [3:0]  reg_offset,
  input  logic [31:0] write_data,
  input  logic [5:0]  cpu_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic        notify_host,
  output logic        eject_valid,
  output logic [5:0]  eject_cpu,
  output logic        ost_valid,
  output logic [5:0]  ost_cpu,
  output logic [31:0] ost_event_code,
  output logic [31:0] ost_status_code
);
  import cser_pkg::*;

  cser_cmd_t  cmd;
  cser_stat_t stat;

  cser_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  cser_dp #(
    .MAX_CPUS (MAX_CPUS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .action          (action),
    .reg_offset      (reg_offset),
    .write_data      (write_data),
    .cpu_index       (cpu_index),
    .read_data       (read_data),
    .notify_host     (notify_host),
    .eject_valid     (eject_valid),
    .eject_cpu       (eject_cpu),
    .ost_valid       (ost_valid),
    .ost_cpu         (ost_cpu),
    .ost_event_code  (ost_event_code),
    .ost_status_code (ost_status_code)
  );

endmodule

[src/cser_checker.sv]
// ----------------------------------------------------------------------------
// cser_checker
// Port-level checks for the CPU standby event register block.
// ----------------------------------------------------------------------------
module cser_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] read_data,
  input logic        notify_host,
  input logic        eject_valid,
  input logic        ost_valid,
  input logic [5:0]  ost_cpu,
  input logic [31:0] ost_event_code,
  input logic [31:0] ost_status_code
);

  // one access in flight: no new transfer while a result is pending
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  a_no_same_cycle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (!out_valid && !in_ready))
    else $error("result or ready right after input transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(read_data)))
    else $error("stalled result changed");

  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($onehot0({notify_host, eject_valid, ost_valid})
                   && (ost_valid || (ost_cpu == 6'd0 && ost_event_code == 32'd0
                                     && ost_status_code == 32'd0))))
    else $error("result kinds overlap or stale OST fields");

endmodule

bind cpu_standby_event_registers cser_checker u_cser_checker (.*);
